/* hdl/cfsp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, result codes and decode tables for the class file structure parser.
// No dependencies.
package cfsp_pkg;

  // Parse phases, one-hot. Pass-through phases are resolved in the same cycle
  // and are never held in the phase register; they are only used as return targets.
  typedef enum logic [28:0] {
    PH_MAGIC   = 29'd1 << 0,
    PH_MINOR   = 29'd1 << 1,
    PH_MAJOR   = 29'd1 << 2,
    PH_PCOUNT  = 29'd1 << 3,
    PH_TAG     = 29'd1 << 4,
    PH_ULEN    = 29'd1 << 5,
    PH_SKIP    = 29'd1 << 6,
    PH_FLAGS   = 29'd1 << 7,
    PH_THIS    = 29'd1 << 8,
    PH_SUPER   = 29'd1 << 9,
    PH_ICOUNT  = 29'd1 << 10,
    PH_FCOUNT  = 29'd1 << 11,
    PH_FACNT   = 29'd1 << 12,
    PH_FANAME  = 29'd1 << 13,
    PH_FALEN   = 29'd1 << 14,
    PH_MCOUNT  = 29'd1 << 15,
    PH_MACNT   = 29'd1 << 16,
    PH_MANAME  = 29'd1 << 17,
    PH_MALEN   = 29'd1 << 18,
    PH_ACOUNT  = 29'd1 << 19,
    PH_CANAME  = 29'd1 << 20,
    PH_CALEN   = 29'd1 << 21,
    PH_DONE    = 29'd1 << 22,
    PH_POOLEND = 29'd1 << 23,
    PH_FAEND   = 29'd1 << 24,
    PH_FMEND   = 29'd1 << 25,
    PH_MAEND   = 29'd1 << 26,
    PH_MMEND   = 29'd1 << 27,
    PH_CAEND   = 29'd1 << 28
  } phase_t;

  // Result kinds
  localparam logic [3:0] KIND_MAGIC  = 4'd0;
  localparam logic [3:0] KIND_MINOR  = 4'd1;
  localparam logic [3:0] KIND_MAJOR  = 4'd2;
  localparam logic [3:0] KIND_PCOUNT = 4'd3;
  localparam logic [3:0] KIND_TAG    = 4'd4;
  localparam logic [3:0] KIND_FLAGS  = 4'd5;
  localparam logic [3:0] KIND_THIS   = 4'd6;
  localparam logic [3:0] KIND_SUPER  = 4'd7;
  localparam logic [3:0] KIND_ICOUNT = 4'd8;
  localparam logic [3:0] KIND_FCOUNT = 4'd9;
  localparam logic [3:0] KIND_MCOUNT = 4'd10;
  localparam logic [3:0] KIND_ACOUNT = 4'd11;
  localparam logic [3:0] KIND_END    = 4'd12;

  // Constant pool tags with special handling
  localparam logic [7:0] TAG_UTF8   = 8'd1;
  localparam logic [7:0] TAG_LONG   = 8'd5;
  localparam logic [7:0] TAG_DOUBLE = 8'd6;

  // Fixed header bytes of each field and method (flags, name, descriptor)
  localparam logic [31:0] MEMBER_HEAD_BYTES = 32'd6;

  // Upper bound on chained pass-through phases resolved while parsing a byte
  localparam int SETTLE_STEPS = 4;

  // Index of the last byte of a multi-byte field in the given phase
  function automatic logic [1:0] last_byte(input phase_t ph);
    logic [1:0] r;
    unique case (ph)
      PH_MAGIC, PH_FALEN, PH_MALEN, PH_CALEN: r = 2'd3;
      PH_TAG:                                 r = 2'd0;
      default:                                r = 2'd1;
    endcase
    return r;
  endfunction

  // Payload bytes after a pool tag; utf8 and unknown tags give zero
  function automatic logic [3:0] entry_bytes(input logic [7:0] t);
    logic [3:0] r;
    unique case (t)
      8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: r = 4'd4;
      8'd5, 8'd6:                                         r = 4'd8;
      8'd7, 8'd8, 8'd16, 8'd19, 8'd20:                    r = 4'd2;
      8'd15:                                              r = 4'd3;
      default:                                            r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/class_file_structure_parser_unit.sv */
`timescale 1ns / 1ps
// Class file structure parser: walks a byte stream and reports each header field.
// Depends on cfsp_pkg (phase type, result kinds, pool tag table).
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   input   | in        | in_valid / in_ready | data_byte
//   result  | out       | out_valid/out_ready | item_kind, item_value, structure_done
//
// One byte per cycle while the result register is not stalled; a byte passes from the
// input register through the parse logic into the result register.
// The phase update and pass-through resolution complete in the cycle a byte is parsed,
// which is what sets the one-byte-per-cycle rate.
// Reset (rst, synchronous) returns the parser to the magic field with empty registers.
// A stalled result holds the parse; the input register takes a byte only while empty.
module class_file_structure_parser_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           item_kind,
  output logic [31:0]          item_value,
  output logic                 structure_done
);
  import cfsp_pkg::*;

  // Input register
  logic       in_full;
  logic [7:0] in_byte;

  // Parser state
  phase_t      parse_phase, parse_phase_next;
  phase_t      return_phase, return_phase_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [15:0] pool_slots_left, pool_slots_left_next;
  logic [15:0] list_items_left, list_items_left_next;
  logic [15:0] member_attributes_left, member_attributes_left_next;
  logic [31:0] skip_bytes_left, skip_bytes_left_next;

  logic        process;
  logic        emit;
  logic [3:0]  kind;
  logic [31:0] value;
  logic        done_flag;

  // Parse a byte when one is held and the result register is free or draining
  assign process  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || process;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_byte <= data_byte;
    end
  end

  // Parse one byte and resolve pass-through phases
  always_comb begin
    logic [31:0] shifted;
    logic        has_kind;
    logic        run_settle;
    logic [1:0]  used;
    phase_t      st;

    parse_phase_next            = parse_phase;
    return_phase_next           = return_phase;
    byte_position_next          = byte_position;
    field_accumulator_next      = field_accumulator;
    pool_slots_left_next        = pool_slots_left;
    list_items_left_next        = list_items_left;
    member_attributes_left_next = member_attributes_left;
    skip_bytes_left_next        = skip_bytes_left;
    shifted    = {field_accumulator[23:0], in_byte};
    has_kind   = 1'b0;
    run_settle = 1'b0;
    used       = 2'd1;
    st         = parse_phase;
    kind       = KIND_END;
    value      = 32'd0;
    emit       = 1'b0;
    done_flag  = 1'b0;

    if (process) begin
      priority if (parse_phase == PH_SKIP) begin
        // Drop one skipped byte
        if (skip_bytes_left != 32'd0) begin
          skip_bytes_left_next = skip_bytes_left - 32'd1;
        end
        run_settle = 1'b1;
        st         = PH_SKIP;
      end else if (parse_phase == PH_DONE) begin
        // Ignore trailing bytes
        run_settle = 1'b0;
      end else if (byte_position < last_byte(parse_phase)) begin
        // Accumulate a byte of a multi-byte field
        field_accumulator_next = shifted;
        byte_position_next     = byte_position + 2'd1;
      end else begin
        // Field complete
        value                  = shifted;
        field_accumulator_next = 32'd0;
        byte_position_next     = 2'd0;
        run_settle             = 1'b1;
        unique case (parse_phase)
          PH_MAGIC: begin
            has_kind = 1'b1; kind = KIND_MAGIC; st = PH_MINOR;
          end
          PH_MINOR: begin
            has_kind = 1'b1; kind = KIND_MINOR; st = PH_MAJOR;
          end
          PH_MAJOR: begin
            has_kind = 1'b1; kind = KIND_MAJOR; st = PH_PCOUNT;
          end
          PH_PCOUNT: begin
            has_kind = 1'b1; kind = KIND_PCOUNT;
            pool_slots_left_next = (shifted[15:0] != 16'd0) ? shifted[15:0] - 16'd1 : 16'd0;
            st = PH_POOLEND;
          end
          PH_TAG: begin
            has_kind = 1'b1; kind = KIND_TAG;
            used = (shifted[7:0] == TAG_LONG || shifted[7:0] == TAG_DOUBLE) ? 2'd2 : 2'd1;
            pool_slots_left_next = (pool_slots_left > 16'(used)) ?
                                   pool_slots_left - 16'(used) : 16'd0;
            if (shifted[7:0] == TAG_UTF8) begin
              st = PH_ULEN;
            end else begin
              skip_bytes_left_next = 32'(entry_bytes(shifted[7:0]));
              return_phase_next    = PH_POOLEND;
              st                   = PH_SKIP;
            end
          end
          PH_ULEN: begin
            skip_bytes_left_next = shifted;
            return_phase_next    = PH_POOLEND;
            st                   = PH_SKIP;
          end
          PH_FLAGS: begin
            has_kind = 1'b1; kind = KIND_FLAGS; st = PH_THIS;
          end
          PH_THIS: begin
            has_kind = 1'b1; kind = KIND_THIS; st = PH_SUPER;
          end
          PH_SUPER: begin
            has_kind = 1'b1; kind = KIND_SUPER; st = PH_ICOUNT;
          end
          PH_ICOUNT: begin
            has_kind = 1'b1; kind = KIND_ICOUNT;
            skip_bytes_left_next = {15'd0, shifted[15:0], 1'b0};
            return_phase_next    = PH_FCOUNT;
            st                   = PH_SKIP;
          end
          PH_FCOUNT: begin
            has_kind = 1'b1; kind = KIND_FCOUNT;
            list_items_left_next = shifted[15:0];
            if (shifted[15:0] != 16'd0) begin
              skip_bytes_left_next = MEMBER_HEAD_BYTES;
              return_phase_next    = PH_FACNT;
              st                   = PH_SKIP;
            end else begin
              st = PH_MCOUNT;
            end
          end
          PH_FACNT: begin
            member_attributes_left_next = shifted[15:0];
            st = (shifted[15:0] != 16'd0) ? PH_FANAME : PH_FMEND;
          end
          PH_FANAME: st = PH_FALEN;
          PH_FALEN: begin
            skip_bytes_left_next = shifted;
            return_phase_next    = PH_FAEND;
            st                   = PH_SKIP;
          end
          PH_MCOUNT: begin
            has_kind = 1'b1; kind = KIND_MCOUNT;
            list_items_left_next = shifted[15:0];
            if (shifted[15:0] != 16'd0) begin
              skip_bytes_left_next = MEMBER_HEAD_BYTES;
              return_phase_next    = PH_MACNT;
              st                   = PH_SKIP;
            end else begin
              st = PH_ACOUNT;
            end
          end
          PH_MACNT: begin
            member_attributes_left_next = shifted[15:0];
            st = (shifted[15:0] != 16'd0) ? PH_MANAME : PH_MMEND;
          end
          PH_MANAME: st = PH_MALEN;
          PH_MALEN: begin
            skip_bytes_left_next = shifted;
            return_phase_next    = PH_MAEND;
            st                   = PH_SKIP;
          end
          PH_ACOUNT: begin
            has_kind = 1'b1; kind = KIND_ACOUNT;
            list_items_left_next = shifted[15:0];
            st = (shifted[15:0] != 16'd0) ? PH_CANAME : PH_DONE;
          end
          PH_CANAME: st = PH_CALEN;
          PH_CALEN: begin
            skip_bytes_left_next = shifted;
            return_phase_next    = PH_CAEND;
            st                   = PH_SKIP;
          end
          default: st = parse_phase;
        endcase
      end

      // Resolve pass-through phases until a phase that waits for a byte
      if (run_settle) begin
        for (int i = 0; i < SETTLE_STEPS; i++) begin
          unique case (st)
            PH_SKIP: begin
              if (skip_bytes_left_next == 32'd0) st = return_phase_next;
            end
            PH_POOLEND: st = (pool_slots_left_next != 16'd0) ? PH_TAG : PH_FLAGS;
            PH_FAEND: begin
              if (member_attributes_left_next != 16'd0) begin
                member_attributes_left_next = member_attributes_left_next - 16'd1;
              end
              st = (member_attributes_left_next != 16'd0) ? PH_FANAME : PH_FMEND;
            end
            PH_FMEND: begin
              if (list_items_left_next != 16'd0) begin
                list_items_left_next = list_items_left_next - 16'd1;
              end
              if (list_items_left_next != 16'd0) begin
                skip_bytes_left_next = MEMBER_HEAD_BYTES;
                return_phase_next    = PH_FACNT;
                st                   = PH_SKIP;
              end else begin
                st = PH_MCOUNT;
              end
            end
            PH_MAEND: begin
              if (member_attributes_left_next != 16'd0) begin
                member_attributes_left_next = member_attributes_left_next - 16'd1;
              end
              st = (member_attributes_left_next != 16'd0) ? PH_MANAME : PH_MMEND;
            end
            PH_MMEND: begin
              if (list_items_left_next != 16'd0) begin
                list_items_left_next = list_items_left_next - 16'd1;
              end
              if (list_items_left_next != 16'd0) begin
                skip_bytes_left_next = MEMBER_HEAD_BYTES;
                return_phase_next    = PH_MACNT;
                st                   = PH_SKIP;
              end else begin
                st = PH_ACOUNT;
              end
            end
            PH_CAEND: begin
              if (list_items_left_next != 16'd0) begin
                list_items_left_next = list_items_left_next - 16'd1;
              end
              st = (list_items_left_next != 16'd0) ? PH_CANAME : PH_DONE;
            end
            default: st = st;
          endcase
        end
        parse_phase_next = st;
        done_flag        = (st == PH_DONE);
        // A counted field reports itself; otherwise completion gives an end marker
        if (has_kind) begin
          emit = 1'b1;
        end else if (done_flag) begin
          emit  = 1'b1;
          kind  = KIND_END;
          value = 32'd0;
        end
      end
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase            <= PH_MAGIC;
      return_phase           <= PH_MAGIC;
      byte_position          <= 2'd0;
      field_accumulator      <= 32'd0;
      pool_slots_left        <= 16'd0;
      list_items_left        <= 16'd0;
      member_attributes_left <= 16'd0;
      skip_bytes_left        <= 32'd0;
    end else begin
      parse_phase            <= parse_phase_next;
      return_phase           <= return_phase_next;
      byte_position          <= byte_position_next;
      field_accumulator      <= field_accumulator_next;
      pool_slots_left        <= pool_slots_left_next;
      list_items_left        <= list_items_left_next;
      member_attributes_left <= member_attributes_left_next;
      skip_bytes_left        <= skip_bytes_left_next;
    end
  end

  // Hold the result transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (process && emit) begin
      item_kind      <= kind;
      item_value     <= value;
      structure_done <= done_flag;
    end
  end

  // Pass-through phases never remain in the phase register
  a_settled_phase: assert property (@(posedge clk) disable iff (rst)
    !(parse_phase == PH_POOLEND || parse_phase == PH_FAEND || parse_phase == PH_FMEND ||
      parse_phase == PH_MAEND || parse_phase == PH_MMEND || parse_phase == PH_CAEND))
    else $error("pass-through phase held in phase register");

  // A held skip phase always has bytes left to skip
  a_skip_pending: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_SKIP |-> skip_bytes_left != 32'd0)
    else $error("skip phase with no bytes left");

  // A completing result means the parser has reached its final phase
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && structure_done |-> parse_phase == PH_DONE)
    else $error("structure_done without final phase");

  // Nothing is reported once the structure is complete and the last result is gone
  a_quiet_after_done: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_DONE && !out_valid |=> !out_valid)
    else $error("result after completion");

  // Partial field bytes only in multi-byte field phases
  a_byte_position: assert property (@(posedge clk) disable iff (rst)
    byte_position != 2'd0 |->
      (parse_phase != PH_TAG && parse_phase != PH_SKIP && parse_phase != PH_DONE))
    else $error("partial field in a single-byte or skip phase");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for class_file_structure_parser_unit: streams one class file
// built at random, with trailing bytes, and checks each reported field. Uses cfsp_pkg.
module testbench;
  import cfsp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_INDEX  = 400;

  // Constant pool tags, including some that the parser does not know
  localparam logic [7:0] TAG_INTEGER     = 8'd3;
  localparam logic [7:0] TAG_FLOAT       = 8'd4;
  localparam logic [7:0] TAG_CLASS       = 8'd7;
  localparam logic [7:0] TAG_STRING      = 8'd8;
  localparam logic [7:0] TAG_FIELDREF    = 8'd9;
  localparam logic [7:0] TAG_METHODREF   = 8'd10;
  localparam logic [7:0] TAG_IFACEREF    = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE    = 8'd12;
  localparam logic [7:0] TAG_MHANDLE     = 8'd15;
  localparam logic [7:0] TAG_MTYPE       = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC     = 8'd17;
  localparam logic [7:0] TAG_INVOKEDYN   = 8'd18;
  localparam logic [7:0] TAG_MODULE      = 8'd19;
  localparam logic [7:0] TAG_PACKAGE     = 8'd20;
  localparam logic [7:0] TAG_UNKNOWN_LO  = 8'd0;
  localparam logic [7:0] TAG_UNKNOWN_GAP = 8'd2;
  localparam logic [7:0] TAG_UNKNOWN_MID = 8'd13;
  localparam logic [7:0] TAG_UNKNOWN_HI  = 8'd255;

  typedef struct packed {
    logic [7:0] value;
    logic       drain;
  } stream_byte_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic        done;
  } field_rec_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  item_kind;
  logic [31:0] item_value;
  logic        structure_done;

  class_file_structure_parser_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .item_kind      (item_kind),
    .item_value     (item_value),
    .structure_done (structure_done)
  );

  stream_byte_t stream_bytes[$];
  field_rec_t   due_fields[$];
  int           stream_len = 1 << 30;
  int           bytes_taken = 0;
  int           fields_seen = 0;
  int           tags_seen = 0;
  int           ends_seen = 0;
  int           fault_count = 0;
  int           cycle_count = 0;
  logic         no_due = 1'b1;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           hold_left = 0;
  logic         hold_used = 1'b0;
  int           pool_slots = 0;
  wire          calm = (bytes_taken + 120 >= stream_len) || (((bytes_taken >> 7) % 3) == 2);

  // Parser state mirrored by the predictor
  phase_t      cur_phase = PH_MAGIC;
  phase_t      resume_phase = PH_MAGIC;
  logic [1:0]  byte_idx = 2'd0;
  logic [31:0] shift_acc = 32'd0;
  logic [15:0] pool_left = 16'd0;
  logic [15:0] list_left = 16'd0;
  logic [15:0] attr_left = 16'd0;
  logic [31:0] skip_left = 32'd0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bytes in one field of the given phase
  function automatic int unsigned field_bytes(input phase_t p);
    case (p)
      PH_MAGIC, PH_FALEN, PH_MALEN, PH_CALEN: return 4;
      PH_TAG:                                 return 1;
      default:                                return 2;
    endcase
  endfunction

  // Payload that follows a pool tag; a utf8 entry carries its own length
  function automatic int unsigned payload_len(input logic [7:0] t);
    case (t)
      TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF, TAG_NAMETYPE,
      TAG_DYNAMIC, TAG_INVOKEDYN:                        return 4;
      TAG_LONG, TAG_DOUBLE:                              return 8;
      TAG_CLASS, TAG_STRING, TAG_MTYPE, TAG_MODULE, TAG_PACKAGE: return 2;
      TAG_MHANDLE:                                       return 3;
      default:                                           return 0;
    endcase
  endfunction

  task automatic log_fault(input string what);
    if (fault_count < 10) $display("MISMATCH @%0t: %s", $time, what);
    fault_count++;
  endtask

  task automatic load_skip(input logic [31:0] n, input phase_t r);
    skip_left    = n;
    resume_phase = r;
  endtask

  // Follow pass-through phases until one that waits for a byte
  task automatic resolve_phase(input phase_t start, output bit done);
    phase_t p;
    bit     go;
    p  = start;
    go = 1'b1;
    while (go) begin
      go = 1'b0;
      case (p)
        PH_SKIP: begin
          if (skip_left == 0) begin
            p  = resume_phase;
            go = 1'b1;
          end
        end
        PH_POOLEND: begin
          if (pool_left != 0) p = PH_TAG;
          else p = PH_FLAGS;
          go = 1'b1;
        end
        PH_FAEND: begin
          if (attr_left != 0) attr_left = attr_left - 16'd1;
          if (attr_left != 0) p = PH_FANAME;
          else p = PH_FMEND;
          go = 1'b1;
        end
        PH_FMEND: begin
          if (list_left != 0) list_left = list_left - 16'd1;
          if (list_left != 0) begin
            load_skip(MEMBER_HEAD_BYTES, PH_FACNT);
            p = PH_SKIP;
          end else p = PH_MCOUNT;
          go = 1'b1;
        end
        PH_MAEND: begin
          if (attr_left != 0) attr_left = attr_left - 16'd1;
          if (attr_left != 0) p = PH_MANAME;
          else p = PH_MMEND;
          go = 1'b1;
        end
        PH_MMEND: begin
          if (list_left != 0) list_left = list_left - 16'd1;
          if (list_left != 0) begin
            load_skip(MEMBER_HEAD_BYTES, PH_MACNT);
            p = PH_SKIP;
          end else p = PH_ACOUNT;
          go = 1'b1;
        end
        PH_CAEND: begin
          if (list_left != 0) list_left = list_left - 16'd1;
          if (list_left != 0) p = PH_CANAME;
          else p = PH_DONE;
          go = 1'b1;
        end
        default: ;
      endcase
    end
    cur_phase = p;
    done      = (p == PH_DONE);
  endtask

  // Advance the mirrored parser by one byte and queue the field it completes
  task automatic walk_byte(input logic [7:0] b);
    phase_t      nxt;
    logic [31:0] v;
    logic [3:0]  kind;
    bit          has_kind;
    bit          done;
    logic [15:0] used;
    field_rec_t  rec;
    if (cur_phase == PH_SKIP) begin
      if (skip_left != 0) skip_left = skip_left - 32'd1;
      if (skip_left == 0) begin
        resolve_phase(resume_phase, done);
        if (done) begin
          rec = '{kind: KIND_END, value: 32'd0, done: 1'b1};
          due_fields.push_back(rec);
        end
      end
      return;
    end
    if (cur_phase == PH_DONE) return;
    shift_acc = {shift_acc[23:0], b};
    if (int'(byte_idx) + 1 < field_bytes(cur_phase)) begin
      byte_idx = byte_idx + 2'd1;
      return;
    end
    v         = shift_acc;
    shift_acc = 32'd0;
    byte_idx  = 2'd0;
    has_kind  = 1'b0;
    kind      = KIND_END;
    nxt       = PH_DONE;
    case (cur_phase)
      PH_MAGIC: begin has_kind = 1; kind = KIND_MAGIC; nxt = PH_MINOR; end
      PH_MINOR: begin has_kind = 1; kind = KIND_MINOR; nxt = PH_MAJOR; end
      PH_MAJOR: begin has_kind = 1; kind = KIND_MAJOR; nxt = PH_PCOUNT; end
      PH_PCOUNT: begin
        has_kind  = 1;
        kind      = KIND_PCOUNT;
        pool_left = (v != 0) ? v[15:0] - 16'd1 : 16'd0;
        nxt       = PH_POOLEND;
      end
      PH_TAG: begin
        has_kind  = 1;
        kind      = KIND_TAG;
        used      = (v[7:0] == TAG_LONG || v[7:0] == TAG_DOUBLE) ? 16'd2 : 16'd1;
        pool_left = (pool_left > used) ? pool_left - used : 16'd0;
        if (v[7:0] == TAG_UTF8) nxt = PH_ULEN;
        else begin
          load_skip(payload_len(v[7:0]), PH_POOLEND);
          nxt = PH_SKIP;
        end
      end
      PH_ULEN: begin load_skip(v, PH_POOLEND); nxt = PH_SKIP; end
      PH_FLAGS: begin has_kind = 1; kind = KIND_FLAGS; nxt = PH_THIS; end
      PH_THIS: begin has_kind = 1; kind = KIND_THIS; nxt = PH_SUPER; end
      PH_SUPER: begin has_kind = 1; kind = KIND_SUPER; nxt = PH_ICOUNT; end
      PH_ICOUNT: begin
        has_kind = 1;
        kind     = KIND_ICOUNT;
        load_skip({v[30:0], 1'b0}, PH_FCOUNT);
        nxt = PH_SKIP;
      end
      PH_FCOUNT: begin
        has_kind  = 1;
        kind      = KIND_FCOUNT;
        list_left = v[15:0];
        if (v != 0) begin
          load_skip(MEMBER_HEAD_BYTES, PH_FACNT);
          nxt = PH_SKIP;
        end else nxt = PH_MCOUNT;
      end
      PH_FACNT: begin
        attr_left = v[15:0];
        if (v != 0) nxt = PH_FANAME;
        else nxt = PH_FMEND;
      end
      PH_FANAME: nxt = PH_FALEN;
      PH_FALEN: begin load_skip(v, PH_FAEND); nxt = PH_SKIP; end
      PH_MCOUNT: begin
        has_kind  = 1;
        kind      = KIND_MCOUNT;
        list_left = v[15:0];
        if (v != 0) begin
          load_skip(MEMBER_HEAD_BYTES, PH_MACNT);
          nxt = PH_SKIP;
        end else nxt = PH_ACOUNT;
      end
      PH_MACNT: begin
        attr_left = v[15:0];
        if (v != 0) nxt = PH_MANAME;
        else nxt = PH_MMEND;
      end
      PH_MANAME: nxt = PH_MALEN;
      PH_MALEN: begin load_skip(v, PH_MAEND); nxt = PH_SKIP; end
      PH_ACOUNT: begin
        has_kind  = 1;
        kind      = KIND_ACOUNT;
        list_left = v[15:0];
        if (v != 0) nxt = PH_CANAME;
        else nxt = PH_DONE;
      end
      PH_CANAME: nxt = PH_CALEN;
      default: begin load_skip(v, PH_CAEND); nxt = PH_SKIP; end
    endcase
    resolve_phase(nxt, done);
    if (has_kind) begin
      rec = '{kind: kind, value: v, done: done};
      due_fields.push_back(rec);
    end else if (done) begin
      rec = '{kind: KIND_END, value: 32'd0, done: 1'b1};
      due_fields.push_back(rec);
    end
  endtask

  // Stream builders; the byte at DRAIN_INDEX waits for all results first
  task automatic push_byte(input logic [7:0] b);
    stream_byte_t sb;
    sb.value = b;
    sb.drain = (stream_bytes.size() == DRAIN_INDEX);
    stream_bytes.push_back(sb);
  endtask

  task automatic push_half(input logic [15:0] h);
    push_byte(h[15:8]);
    push_byte(h[7:0]);
  endtask

  task automatic push_word(input logic [31:0] w);
    push_half(w[31:16]);
    push_half(w[15:0]);
  endtask

  task automatic push_noise(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_attribute(input int unsigned len);
    push_noise(2);
    push_word(len);
    push_noise(len);
  endtask

  // Each member: flags, name and descriptor, then its attribute list
  task automatic push_members(input int unsigned count);
    int unsigned i, j, n_attr;
    for (i = 0; i < count; i++) begin
      push_noise(6);
      n_attr = $urandom_range(0, 3);
      push_half(16'(n_attr));
      for (j = 0; j < n_attr; j++) push_attribute($urandom_range(0, 12));
    end
  endtask

  // Drive the stream; hold valid and payload until the transaction completes
  always @(posedge clk) begin : drive_proc
    stream_byte_t sb;
    if (rst) begin
      in_valid  <= 1'b0;
      data_byte <= 8'd0;
      send_gap  <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (stream_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (stream_bytes[0].drain && (in_valid || !no_due)) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 15);
      end else begin
        sb = stream_bytes.pop_front();
        in_valid  <= 1'b1;
        data_byte <= sb.value;
      end
    end
  end

  // Result side: random stalls plus one long hold-off early in the run
  always @(posedge clk) begin : accept_proc
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_used && fields_seen >= 6) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_used <= 1'b1;
    end else if (recv_gap != 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      recv_gap  <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check results against the oldest expectation, then predict accepted bytes
  always @(posedge clk) begin : watch_proc
    field_rec_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        fields_seen <= fields_seen + 1;
        if (item_kind == KIND_TAG) tags_seen <= tags_seen + 1;
        if (item_kind == KIND_END) ends_seen <= ends_seen + 1;
        if (due_fields.size() == 0) begin
          log_fault($sformatf("unexpected result kind=%0d value=%h done=%0b",
                              item_kind, item_value, structure_done));
        end else begin
          want = due_fields.pop_front();
          if (item_kind !== want.kind || item_value !== want.value ||
              structure_done !== want.done)
            log_fault($sformatf("expected kind=%0d value=%h done=%0b, got kind=%0d value=%h done=%0b",
                                want.kind, want.value, want.done,
                                item_kind, item_value, structure_done));
        end
      end
      if (in_valid && in_ready) begin
        walk_byte(data_byte);
        bytes_taken <= bytes_taken + 1;
      end
      no_due <= (due_fields.size() == 0);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin : limit_proc
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main_proc
    logic [7:0]  opening_tags[22];
    logic [7:0]  tag;
    int unsigned i, r, n_attr, member_count, len;
    int          slots;
    logic        empty_pool;
    opening_tags = '{TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS,
                     TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF, TAG_NAMETYPE,
                     TAG_MHANDLE, TAG_MTYPE, TAG_DYNAMIC, TAG_INVOKEDYN, TAG_MODULE,
                     TAG_PACKAGE, TAG_UNKNOWN_LO, TAG_UNKNOWN_GAP, TAG_UNKNOWN_MID,
                     TAG_UNKNOWN_HI, TAG_UTF8};

    // Header with extreme values
    r = $urandom_range(0, 2);
    push_word(r == 0 ? 32'hFFFF_FFFF : (r == 1 ? 32'h0000_0000 : 32'hCAFE_BABE));
    push_half($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    push_half($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);

    // Pool: mostly large; sometimes a count of zero or one leaves it empty
    r = $urandom_range(0, 9);
    if (r < 2) begin
      pool_slots = 0;
      push_half(16'(r));
    end else begin
      pool_slots = $urandom_range(110, 150);
      push_half(16'(pool_slots + 1));
    end
    empty_pool = (pool_slots == 0);
    slots = pool_slots;
    i = 0;
    while (slots > 0) begin
      if (slots == 1) tag = $urandom_range(0, 1) ? TAG_LONG : TAG_DOUBLE;
      else if (i < 22) tag = opening_tags[i];
      else begin
        r = $urandom_range(0, 24);
        tag = (r <= 20) ? r[7:0] : 8'($urandom_range(21, 255));
      end
      i++;
      push_byte(tag);
      if (tag == TAG_UTF8) begin
        len = ($urandom_range(0, 15) == 0) ? 40 : $urandom_range(0, 10);
        push_half(16'(len));
        push_noise(len);
      end else begin
        push_noise(payload_len(tag));
      end
      slots = slots - ((tag == TAG_LONG || tag == TAG_DOUBLE) ? 2 : 1);
    end

    // Flags, this, super, interfaces
    push_half($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    push_half(16'($urandom_range(0, 65535)));
    push_half(16'($urandom_range(0, 65535)));
    r = $urandom_range(3, 25);
    push_half(16'(r));
    push_noise(2 * r);

    // Fields and methods; the lists are longer when the pool is empty
    for (i = 0; i < 2; i++) begin
      if ($urandom_range(0, 7) == 0) member_count = 0;
      else if (empty_pool) member_count = $urandom_range(18, 24);
      else member_count = $urandom_range(6, 12);
      push_half(16'(member_count));
      push_members(member_count);
    end

    // Class attributes: none ends on the count itself, a last empty one on its length, else inside a skip
    n_attr = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
    push_half(16'(n_attr));
    for (i = 0; i < n_attr; i++) begin
      if (i + 1 == n_attr && $urandom_range(0, 1)) push_attribute(0);
      else push_attribute($urandom_range(0, 12));
    end

    // Trailing bytes after completion are ignored
    push_noise(24);
    stream_len = stream_bytes.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != stream_len) @(posedge clk);
    while (!no_due) @(posedge clk);
    repeat (20) @(posedge clk);
    if (due_fields.size() != 0)
      log_fault($sformatf("%0d expected results never arrived", due_fields.size()));

    $display("summary: %0d stream bytes, %0d pool slots, %0d results checked (%0d tags, %0d end markers)",
             stream_len, pool_slots, fields_seen, tags_seen, ends_seen);
    $display("summary: %0d mismatches, long result hold-off %0s", fault_count,
             hold_used ? "applied" : "not reached");
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/cfsp_pkg.sv
hdl/class_file_structure_parser_unit.sv
tb/testbench.sv
